[hdl/pwc_pkg.sv]
`timescale 1ns / 1ps

package pwc_pkg;

  // default configuration
  localparam int CHANNELS_DEFAULT  = 8;
  localparam int TIME_BITS_DEFAULT = 16;

  // width of the channel query field
  localparam int QUERY_BITS = 4;

  // query hit flag plus the queried pin's newest, middle and oldest edge times after the update
  typedef struct packed {
    logic hit;
    logic [31:0] newest;
    logic [31:0] middle;
    logic [31:0] oldest;
  } pwc_tap_t;

endpackage

[hdl/multichannel_pulse_width_capture.sv]
`timescale 1ns / 1ps

// multichannel pulse-width capture
// input channel (in_valid/in_ready): one sample of the pin levels, its
// timestamp and the pin to query. every pin that toggled since the last
// sample shifts its three-deep edge history and records the timestamp.
// output channel (out_valid/out_ready): one pulse_width_us per sample, the
// smaller of the queried pin's two latest edge intervals after the update,
// wrapping at 2^TIME_BITS; a query at or beyond CHANNELS gives 0.
// throughput: one sample per cycle while in_ready is high, set by the single
// register stage from the input port through the history update to the
// output register.
// reset clears the previous levels and all edge histories to zero, and
// drops any pending result.
// when the receiver stalls, a second output slot takes one more sample;
// after that in_ready drops until a result is taken.
module multichannel_pulse_width_capture #(
  parameter int CHANNELS  = pwc_pkg::CHANNELS_DEFAULT,
  parameter int TIME_BITS = pwc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CHANNELS-1:0]            port_levels,
  input  logic [TIME_BITS-1:0]           timestamp_us,
  input  logic [pwc_pkg::QUERY_BITS-1:0] query_channel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [TIME_BITS-1:0]           pulse_width_us
);

  logic                 transfer;
  pwc_pkg::pwc_tap_t    tap;
  logic [TIME_BITS-1:0] width;

  assign transfer = in_valid && in_ready;

  pwc_history #(
    .CHANNELS (CHANNELS),
    .TIME_BITS(TIME_BITS)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .update   (transfer),
    .levels   (port_levels),
    .timestamp(timestamp_us),
    .query    (query_channel),
    .tap      (tap)
  );

  pwc_width #(
    .TIME_BITS(TIME_BITS)
  ) u_width (
    .tap  (tap),
    .width(width)
  );

  pwc_out_buf #(
    .WIDTH(TIME_BITS)
  ) u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (transfer),
    .push_data(width),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (pulse_width_us)
  );

endmodule

[hdl/pwc_history.sv]
`timescale 1ns / 1ps

module pwc_history #(
  parameter int CHANNELS  = pwc_pkg::CHANNELS_DEFAULT,
  parameter int TIME_BITS = pwc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         update,
  input  logic [CHANNELS-1:0]          levels,
  input  logic [TIME_BITS-1:0]         timestamp,
  input  logic [pwc_pkg::QUERY_BITS-1:0] query,
  output pwc_pkg::pwc_tap_t            tap
);

  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0]  prev_levels;
  logic [TIME_BITS-1:0] edge_newest [CHANNELS];
  logic [TIME_BITS-1:0] edge_middle [CHANNELS];
  logic [TIME_BITS-1:0] edge_oldest [CHANNELS];

  logic [TIME_BITS-1:0] edge_newest_next [CHANNELS];
  logic [TIME_BITS-1:0] edge_middle_next [CHANNELS];
  logic [TIME_BITS-1:0] edge_oldest_next [CHANNELS];

  logic [CHANNELS-1:0] changed;
  logic                hit;
  logic [IDX_BITS-1:0] sel;

  assign changed = levels ^ prev_levels;

  // every pin that toggled shifts its history and takes the new time
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (changed[i]) begin
        edge_newest_next[i] = timestamp;
        edge_middle_next[i] = edge_newest[i];
        edge_oldest_next[i] = edge_middle[i];
      end else begin
        edge_newest_next[i] = edge_newest[i];
        edge_middle_next[i] = edge_middle[i];
        edge_oldest_next[i] = edge_oldest[i];
      end
    end
  end

  // query reads the post-update history
  assign hit = (32'(query) < CHANNELS);
  assign sel = hit ? IDX_BITS'(query) : '0;

  always_comb begin
    tap.hit    = hit;
    tap.newest = 32'(edge_newest_next[sel]);
    tap.middle = 32'(edge_middle_next[sel]);
    tap.oldest = 32'(edge_oldest_next[sel]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        edge_newest[i] <= '0;
        edge_middle[i] <= '0;
        edge_oldest[i] <= '0;
      end
    end else if (update) begin
      prev_levels <= levels;
      for (int i = 0; i < CHANNELS; i++) begin
        edge_newest[i] <= edge_newest_next[i];
        edge_middle[i] <= edge_middle_next[i];
        edge_oldest[i] <= edge_oldest_next[i];
      end
    end
  end

endmodule

[hdl/pwc_width.sv]
`timescale 1ns / 1ps

module pwc_width #(
  parameter int TIME_BITS = pwc_pkg::TIME_BITS_DEFAULT
) (
  input  pwc_pkg::pwc_tap_t    tap,
  output logic [TIME_BITS-1:0] width
);

  logic [TIME_BITS-1:0] newest;
  logic [TIME_BITS-1:0] middle;
  logic [TIME_BITS-1:0] oldest;
  logic [TIME_BITS-1:0] recent;
  logic [TIME_BITS-1:0] earlier;

  assign newest = TIME_BITS'(tap.newest);
  assign middle = TIME_BITS'(tap.middle);
  assign oldest = TIME_BITS'(tap.oldest);

  // intervals wrap with the timestamp
  assign recent  = newest - middle;
  assign earlier = middle - oldest;

  always_comb begin
    if (!tap.hit) begin
      width = '0;
    end else if (recent < earlier) begin
      width = recent;
    end else begin
      width = earlier;
    end
  end

endmodule

[hdl/pwc_out_buf.sv]
`timescale 1ns / 1ps

module pwc_out_buf #(
  parameter int WIDTH = pwc_pkg::TIME_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             pop;

  // skid slot takes one more sample while the output is stalled
  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end else begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end
  end

endmodule

[hdl/pwc_checker.sv]
`timescale 1ns / 1ps

module pwc_checker #(
  parameter int CHANNELS  = pwc_pkg::CHANNELS_DEFAULT,
  parameter int TIME_BITS = pwc_pkg::TIME_BITS_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [pwc_pkg::QUERY_BITS-1:0] query_channel,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [TIME_BITS-1:0]           pulse_width_us
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_width_us))
    else $error("output result changed while stalled");

  // a transfer into an empty output shows up in the following cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after transfer");

  // query of no valid pin reads zero
  a_no_pin: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && (32'(query_channel) >= CHANNELS)
    |=> pulse_width_us == '0)
    else $error("nonzero width for invalid query");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pending result after reset");

endmodule

bind multichannel_pulse_width_capture pwc_checker #(
  .CHANNELS (CHANNELS),
  .TIME_BITS(TIME_BITS)
) u_pwc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .query_channel (query_channel),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pulse_width_us(pulse_width_us)
);

[tb/sv/multichannel_pulse_width_capture_tb.sv]
`timescale 1ns / 1ps

module multichannel_pulse_width_capture_tb;

  localparam int CH = pwc_pkg::CHANNELS_DEFAULT;
  localparam int TW = pwc_pkg::TIME_BITS_DEFAULT;
  localparam int QW = pwc_pkg::QUERY_BITS;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS = 10;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [CH-1:0] port_levels = '0;
  logic [TW-1:0] timestamp_us = '0;
  logic [QW-1:0] query_channel = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [TW-1:0] pulse_width_us;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predicted pulse widths, oldest first
  logic [TW-1:0] width_queue[$];
  logic [TW-1:0] expected_width;

  // predictor state
  logic [CH-1:0] levels_seen = '0;
  logic [TW-1:0] edge_newest[CH] = '{default: '0};
  logic [TW-1:0] edge_middle[CH] = '{default: '0};
  logic [TW-1:0] edge_oldest[CH] = '{default: '0};

  // running pulse-train state for the random part
  logic [CH-1:0] train_levels = '0;
  logic [TW-1:0] train_time = '0;

  multichannel_pulse_width_capture #(
    .CHANNELS (CH),
    .TIME_BITS(TW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .port_levels   (port_levels),
    .timestamp_us  (timestamp_us),
    .query_channel (query_channel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pulse_width_us(pulse_width_us)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("multichannel_pulse_width_capture_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // shift histories of toggled pins, then measure the queried pin
  function automatic logic [TW-1:0] capture_and_measure(input logic [CH-1:0] levels,
                                                        input logic [TW-1:0] now,
                                                        input logic [QW-1:0] query);
    logic [CH-1:0] toggled;
    logic [TW-1:0] recent;
    logic [TW-1:0] earlier;
    toggled = levels ^ levels_seen;
    levels_seen = levels;
    for (int i = 0; i < CH; i++) begin
      if (toggled[i]) begin
        edge_oldest[i] = edge_middle[i];
        edge_middle[i] = edge_newest[i];
        edge_newest[i] = now;
      end
    end
    if (query >= CH) return '0;
    recent = edge_newest[query] - edge_middle[query];
    earlier = edge_middle[query] - edge_oldest[query];
    return (recent < earlier) ? recent : earlier;
  endfunction

  task automatic note_mismatch(input string what, input logic [TW-1:0] exp_w,
                               input logic [TW-1:0] act_w);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch (%s) at cycle %0d: expected pulse_width_us %h, got %h",
               what, cycle_count, exp_w, act_w);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (width_queue.size() == 0) begin
          note_mismatch("unexpected result", '0, pulse_width_us);
        end else begin
          expected_width = width_queue.pop_front();
          if (pulse_width_us !== expected_width) begin
            note_mismatch("wrong width", expected_width, pulse_width_us);
          end
        end
      end
      if (in_valid && in_ready) begin
        width_queue.push_back(capture_and_measure(port_levels, timestamp_us, query_channel));
      end
    end
  end

  // valid stays high between back-to-back transfers
  task automatic send_sample(input logic [CH-1:0] levels, input logic [TW-1:0] now,
                             input logic [QW-1:0] query);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    port_levels <= levels;
    timestamp_us <= now;
    query_channel <= query;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (width_queue.size() != 0);
  endtask

  task automatic test_no_edge_yet();
    send_sample(8'h00, 16'hffff, 4'd5);
    send_sample(8'h20, 16'h1234, 4'd5);
    send_sample(8'h20, 16'h1300, 4'd3);
  endtask

  task automatic test_first_edges_and_widths();
    send_sample(8'hff, 16'h0100, 4'd0);
    send_sample(8'hff, 16'h0200, 4'd1);
    send_sample(8'h00, 16'h0300, 4'd0);
    send_sample(8'hff, 16'h0450, 4'd0);
    send_sample(8'hfe, 16'h0460, 4'd0);
  endtask

  task automatic test_no_valid_pin();
    send_sample(8'h01, 16'h0500, 4'd8);
    send_sample(8'h80, 16'h0600, 4'd15);
    send_sample(8'h7f, 16'h0700, 4'd9);
    send_sample(8'hf0, 16'h0800, 4'd12);
  endtask

  task automatic test_timestamp_wrap();
    send_sample(8'h00, 16'hfff0, 4'd7);
    send_sample(8'h80, 16'h0010, 4'd7);
    send_sample(8'h00, 16'h0030, 4'd7);
    send_sample(8'h80, 16'hffff, 4'd7);
  endtask

  task automatic test_field_extremes();
    send_sample(8'h00, 16'h0000, 4'd0);
    send_sample(8'hff, 16'hffff, 4'd7);
    send_sample(8'haa, 16'h0000, 4'd1);
    send_sample(8'h55, 16'h8000, 4'd6);
    send_sample(8'haa, 16'h7fff, 4'd2);
    send_sample(8'h55, 16'hffff, 4'd4);
    send_sample(8'h00, 16'h0001, 4'd3);
  endtask

  task automatic test_random_trains(input int count, input int s_pct, input int r_pct);
    logic [CH-1:0] toggle;
    logic [QW-1:0] query;
    sender_idle_pct = s_pct;
    receiver_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      if ($urandom_range(99) < 80) begin
        // occasional big jumps to cover wrap of the time base
        if ($urandom_range(19) == 0) train_time = train_time + TW'($urandom_range(65535));
        else train_time = train_time + TW'($urandom_range(400, 1));
        toggle = '0;
        for (int i = 0; i < CH; i++) begin
          if ($urandom_range(99) < 35) toggle[i] = 1'b1;
        end
        train_levels = train_levels ^ toggle;
        if ($urandom_range(9) == 0) query = QW'($urandom_range(15, CH));
        else query = QW'($urandom_range(CH - 1));
        send_sample(train_levels, train_time, query);
      end else begin
        send_sample(CH'($urandom_range(255)), TW'($urandom_range(65535)),
                    QW'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    receiver_idle_pct = 30;
    test_no_edge_yet();
    test_first_edges_and_widths();
    test_no_valid_pin();
    test_timestamp_wrap();
    test_field_extremes();
    wait_for_results();
    test_random_trains(250, 22, 58);
    test_random_trains(250, 58, 22);
    test_random_trains(250, 0, 0);
    in_valid <= 1'b0;
    do @(posedge clk); while (width_queue.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && width_queue.size() == 0) begin
      $display("multichannel_pulse_width_capture_tb OK");
    end else begin
      $display("multichannel_pulse_width_capture_tb NOT OK");
    end
    $finish;
  end

endmodule
